/* sv/ocv_pkg.sv */
// ----------------------------------------------------------------------------
// ocv_pkg
// Shared types, offsets, codes and helpers of the calibration image validator.
// ----------------------------------------------------------------------------
package ocv_pkg;

   localparam int POS_W       = 13;
   localparam int METRIC_W    = 54;
   localparam int WORD_W      = 16;
   localparam int SQ_W        = 2 * WORD_W;
   localparam int SCALE_SHIFT = 20;
   localparam int DIVIDEND_W  = SQ_W + SCALE_SHIFT;
   localparam int WB_BYTES    = 12;
   localparam int CHANNELS    = 3;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = METRIC_W;

   localparam logic [POS_W-1:0] MOD_FLAG        = 13'h0000;
   localparam logic [POS_W-1:0] VENDOR_POS      = 13'h0001;
   localparam logic [POS_W-1:0] MOD_CSUM        = 13'h001F;
   localparam logic [POS_W-1:0] SER_FLAG        = 13'h0045;
   localparam logic [POS_W-1:0] SER_CSUM        = 13'h0065;
   localparam logic [POS_W-1:0] WB_FLAG         = 13'h0CAB;
   localparam logic [POS_W-1:0] WB_CAPTURE_LAST = 13'h0CB7;
   localparam logic [POS_W-1:0] WB_CSUM         = 13'h0CE0;
   localparam logic [POS_W-1:0] LS_FLAG         = 13'h0CE1;
   localparam logic [POS_W-1:0] LS_CSUM         = 13'h143E;
   localparam logic [POS_W-1:0] LAST_OFFSET     = 13'h143E;

   localparam logic [METRIC_W-1:0] METRIC_MAX      = {METRIC_W{1'b1}};
   localparam logic [METRIC_W-1:0] AWB_LIMIT_RESET = 54'd23593;
   localparam logic [7:0]          VENDOR_RESET    = 8'h05;
   localparam logic [7:0]          FLAG_SET        = 8'h01;
   localparam logic [3:0]          ALL_PASSED      = 4'hF;

   localparam logic [CSR_INDEX_W-1:0] CSR_AWB_LIMIT       = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_EXPECTED_VENDOR = 2'd1;

   localparam logic [2:0] STATUS_OK            = 3'd0;
   localparam logic [2:0] STATUS_GROUP_INVALID = 3'd1;
   localparam logic [2:0] STATUS_MODULE_ERROR  = 3'd2;
   localparam logic [2:0] STATUS_CHECKSUM_ERR  = 3'd3;
   localparam logic [2:0] STATUS_AWB_RANGE     = 3'd4;

   typedef struct packed {
      logic [7:0] otp_byte;
      logic       restart;
   } req_payload_type;

   typedef struct packed {
      logic [2:0]          status;
      logic [METRIC_W-1:0] awb_metric;
   } rsp_payload_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_SQ_DIFF,
      ST_SQ_GOLD,
      ST_DIVIDE,
      ST_ACCUM,
      ST_FINISH,
      ST_EMIT
   } state_type;

   // (sum mod 255) + 1 == b, by folding bytes
   function automatic logic checksum_ok(input logic [18:0] sum, input logic [7:0] b);
      logic [9:0] fold1;
      logic [8:0] fold2;
      logic [7:0] residue;
      fold1 = 10'(sum[7:0]) + 10'(sum[15:8]) + 10'(sum[18:16]);
      fold2 = 9'(fold1[7:0]) + 9'(fold1[9:8]);
      if (fold2 >= 9'd255) begin
         residue = 8'(fold2 - 9'd255);
      end else begin
         residue = fold2[7:0];
      end
      return (residue != 8'hFF) && (b == residue + 8'd1);
   endfunction

endpackage

/* sv/ocv_divider.sv */
// ----------------------------------------------------------------------------
// ocv_divider
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ocv_divider #(
   parameter int DVD_W = ocv_pkg::DIVIDEND_W,
   parameter int DVS_W = ocv_pkg::SQ_W
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DVD_W-1:0] dividend,
   input  logic [DVS_W-1:0] divisor,
   output logic             done,
   output logic [DVD_W-1:0] quotient
);

   localparam int CNT_W = $clog2(DVD_W);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DVD_W - 1);

   logic             busy_ff, busy_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [DVD_W-1:0] quo_ff, quo_in;
   logic [DVS_W-1:0] rem_ff, rem_in;
   logic [DVS_W-1:0] dvs_ff, dvs_in;
   logic [DVS_W:0]   rem_sh;
   logic [DVS_W:0]   dvs_ext;
   logic [DVS_W:0]   diff;
   logic             ge;

   assign rem_sh  = {rem_ff, quo_ff[DVD_W-1]};
   assign dvs_ext = {1'b0, dvs_ff};
   assign ge      = rem_sh >= dvs_ext;
   assign diff    = rem_sh - dvs_ext;

   assign done     = busy_ff && (cnt_ff == CNT_LAST);
   assign quotient = quo_ff;

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         quo_in = {quo_ff[DVD_W-2:0], ge};
         rem_in = ge ? diff[DVS_W-1:0] : rem_sh[DVS_W-1:0];
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_LAST) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

endmodule

/* sv/otp_calibration_validator.sv */
// ----------------------------------------------------------------------------
// otp_calibration_validator
// Checks a calibration image beat by beat and reports one status per image.
// ----------------------------------------------------------------------------
//  channel | direction | handshake        | beat
//  req     | in        | valid / stall    | otp_byte, restart
//  rsp     | out       | valid / stall    | status, awb_metric
//  csr     | in        | valid / ready    | index, data
//
//  The final byte goes from the decision straight to the result for
//  statuses 1 to 3 and for a zero golden value; otherwise it takes,
//  per channel, two passes through the shared 16x16 multiplier and 52 steps
//  of the divider.
//  Reset is synchronous; it clears the image state and loads register defaults.
//  Bytes are taken while a result waits on rsp_stall; the final byte holds
//  in the sequencer until the result register is free.
// ----------------------------------------------------------------------------
module otp_calibration_validator (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       req_valid,
   output logic                                       req_stall,
   input  ocv_pkg::req_payload_type                   req_payload,
   output logic                                       rsp_valid,
   input  logic                                       rsp_stall,
   output ocv_pkg::rsp_payload_type                   rsp_payload,
   input  logic                                       csr_valid,
   output logic                                       csr_ready,
   input  logic [ocv_pkg::CSR_INDEX_W-1:0]            csr_index,
   input  logic [ocv_pkg::CSR_DATA_W-1:0]             csr_data
);

   import ocv_pkg::*;

   localparam logic [1:0] CHAN_LAST = 2'(CHANNELS - 1);

   state_type state_ff, state_in;

   logic [POS_W-1:0]    byte_position_ff, byte_position_in;
   logic [12:0]         module_sum_ff, module_sum_in;
   logic [12:0]         serial_sum_ff, serial_sum_in;
   logic [13:0]         wb_sum_ff, wb_sum_in;
   logic [18:0]         shading_sum_ff, shading_sum_in;
   logic [3:0]          flags_ok_ff, flags_ok_in;
   logic                vendor_ok_ff, vendor_ok_in;
   logic [3:0]          checks_ok_ff, checks_ok_in;
   logic [7:0]          wb_byte_ff [WB_BYTES];
   logic [7:0]          wb_byte_in [WB_BYTES];
   logic [METRIC_W-1:0] awb_limit_ff;
   logic [7:0]          expected_vendor_ff;
   logic [1:0]          chan_ff, chan_in;
   logic [SQ_W-1:0]     dsq_ff, dsq_in;
   logic [METRIC_W-1:0] metric_ff, metric_in;
   logic [2:0]          status_ff, status_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_payload_type     rsp_payload_ff, rsp_payload_in;

   logic                req_fire;
   logic [7:0]          b;
   logic [POS_W-1:0]    pos;
   logic                new_image;
   logic                wb_capture;
   logic                wb_rotate;
   logic [WORD_W-1:0]   unit_word;
   logic [WORD_W-1:0]   golden_word;
   logic [WORD_W-1:0]   diff_word;
   logic                golden_zero;
   logic [WORD_W-1:0]   mul_a, mul_b;
   logic [SQ_W-1:0]     product;
   logic                div_start;
   logic                div_done;
   logic [DIVIDEND_W-1:0] quotient;
   logic [METRIC_W:0]   metric_sum;

   assign req_fire  = req_valid && !req_stall;
   assign b         = req_payload.otp_byte;
   assign pos       = req_payload.restart ? '0 : byte_position_ff;
   assign new_image = (pos == MOD_FLAG);
   assign wb_capture = req_fire && (pos > WB_FLAG) && (pos <= WB_CAPTURE_LAST);

   assign unit_word   = {wb_byte_ff[0], wb_byte_ff[1]};
   assign golden_word = {wb_byte_ff[6], wb_byte_ff[7]};
   assign diff_word   = (unit_word > golden_word) ? unit_word - golden_word
                                                   : golden_word - unit_word;
   assign golden_zero = ({wb_byte_ff[6], wb_byte_ff[7]} == '0)
                     || ({wb_byte_ff[8], wb_byte_ff[9]} == '0)
                     || ({wb_byte_ff[10], wb_byte_ff[11]} == '0);

   assign product    = SQ_W'(mul_a) * SQ_W'(mul_b);
   assign metric_sum = (METRIC_W + 1)'(metric_ff) + (METRIC_W + 1)'(quotient);

   assign csr_ready   = 1'b1;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   ocv_divider #(
      .DVD_W(DIVIDEND_W),
      .DVS_W(SQ_W)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend ({dsq_ff, {SCALE_SHIFT{1'b0}}}),
      .divisor  (product),
      .done     (div_done),
      .quotient (quotient)
   );

   // per-byte image tracking
   always_comb begin
      byte_position_in = byte_position_ff;
      module_sum_in    = module_sum_ff;
      serial_sum_in    = serial_sum_ff;
      wb_sum_in        = wb_sum_ff;
      shading_sum_in   = shading_sum_ff;
      flags_ok_in      = flags_ok_ff;
      vendor_ok_in     = vendor_ok_ff;
      checks_ok_in     = checks_ok_ff;
      if (req_fire) begin
         if (new_image) begin
            module_sum_in  = '0;
            serial_sum_in  = '0;
            wb_sum_in      = '0;
            shading_sum_in = '0;
            flags_ok_in    = '0;
            vendor_ok_in   = 1'b0;
            checks_ok_in   = '0;
         end
         flags_ok_in = flags_ok_in | {(pos == LS_FLAG) && (b == FLAG_SET),
                                      (pos == WB_FLAG) && (b == FLAG_SET),
                                      (pos == SER_FLAG) && (b == FLAG_SET),
                                      (pos == MOD_FLAG) && (b == FLAG_SET)};
         if (pos == VENDOR_POS) begin
            vendor_ok_in = (b == expected_vendor_ff);
         end
         checks_ok_in = checks_ok_in
            | {(pos == LS_CSUM) && checksum_ok(shading_sum_in, b),
               (pos == WB_CSUM) && checksum_ok(19'(wb_sum_in), b),
               (pos == SER_CSUM) && checksum_ok(19'(serial_sum_in), b),
               (pos == MOD_CSUM) && checksum_ok(19'(module_sum_in), b)};
         if ((pos > MOD_FLAG) && (pos < MOD_CSUM)) begin
            module_sum_in = module_sum_in + 13'(b);
         end
         if ((pos > SER_FLAG) && (pos < SER_CSUM)) begin
            serial_sum_in = serial_sum_in + 13'(b);
         end
         if ((pos > WB_FLAG) && (pos < WB_CSUM)) begin
            wb_sum_in = wb_sum_in + 14'(b);
         end
         if ((pos > LS_FLAG) && (pos < LS_CSUM)) begin
            shading_sum_in = shading_sum_in + 19'(b);
         end
         byte_position_in = (pos == LAST_OFFSET) ? '0 : pos + 13'd1;
      end
   end

   // AWB bytes: shift in on capture, rotate one word per channel
   always_comb begin
      for (int i = 0; i < WB_BYTES; i++) begin
         wb_byte_in[i] = wb_byte_ff[i];
      end
      if (wb_capture) begin
         for (int i = 0; i < WB_BYTES - 1; i++) begin
            wb_byte_in[i] = wb_byte_ff[i+1];
         end
         wb_byte_in[WB_BYTES-1] = b;
      end else if (wb_rotate) begin
         for (int i = 0; i < 4; i++) begin
            wb_byte_in[i]   = wb_byte_ff[i+2];
            wb_byte_in[i+6] = wb_byte_ff[i+8];
         end
         wb_byte_in[4]  = wb_byte_ff[0];
         wb_byte_in[5]  = wb_byte_ff[1];
         wb_byte_in[10] = wb_byte_ff[6];
         wb_byte_in[11] = wb_byte_ff[7];
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire && (pos == LAST_OFFSET)) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if ((flags_ok_ff != ALL_PASSED) || !vendor_ok_ff
                || (checks_ok_ff != ALL_PASSED) || golden_zero) begin
               state_in = ST_EMIT;
            end else begin
               state_in = ST_SQ_DIFF;
            end
         end
         ST_SQ_DIFF: state_in = ST_SQ_GOLD;
         ST_SQ_GOLD: state_in = ST_DIVIDE;
         ST_DIVIDE: begin
            if (div_done) begin
               state_in = ST_ACCUM;
            end
         end
         ST_ACCUM: begin
            state_in = (chan_ff == CHAN_LAST) ? ST_FINISH : ST_SQ_DIFF;
         end
         ST_FINISH: state_in = ST_EMIT;
         ST_EMIT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_stall      = (state_ff != ST_IDLE);
      chan_in        = chan_ff;
      dsq_in         = dsq_ff;
      metric_in      = metric_ff;
      status_in      = status_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_payload_in = rsp_payload_ff;
      wb_rotate      = 1'b0;
      div_start      = 1'b0;
      mul_a          = diff_word;
      mul_b          = diff_word;
      case (state_ff)
         ST_DECIDE: begin
            chan_in   = '0;
            metric_in = '0;
            if (flags_ok_ff != ALL_PASSED) begin
               status_in = STATUS_GROUP_INVALID;
            end else if (!vendor_ok_ff) begin
               status_in = STATUS_MODULE_ERROR;
            end else if (checks_ok_ff != ALL_PASSED) begin
               status_in = STATUS_CHECKSUM_ERR;
            end else if (golden_zero) begin
               status_in = STATUS_AWB_RANGE;
               metric_in = METRIC_MAX;
            end else begin
               status_in = STATUS_OK;
            end
         end
         ST_SQ_DIFF: begin
            dsq_in = product;
         end
         ST_SQ_GOLD: begin
            mul_a     = golden_word;
            mul_b     = golden_word;
            div_start = 1'b1;
         end
         ST_ACCUM: begin
            metric_in = metric_sum[METRIC_W] ? METRIC_MAX : metric_sum[METRIC_W-1:0];
            chan_in   = chan_ff + 2'd1;
            wb_rotate = 1'b1;
         end
         ST_FINISH: begin
            status_in = (metric_ff > awb_limit_ff) ? STATUS_AWB_RANGE : STATUS_OK;
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in              = 1'b1;
               rsp_payload_in.status     = status_ff;
               rsp_payload_in.awb_metric = metric_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         byte_position_ff <= '0;
         module_sum_ff    <= '0;
         serial_sum_ff    <= '0;
         wb_sum_ff        <= '0;
         shading_sum_ff   <= '0;
         flags_ok_ff      <= '0;
         vendor_ok_ff     <= 1'b0;
         checks_ok_ff     <= '0;
         chan_ff          <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff         <= state_in;
         byte_position_ff <= byte_position_in;
         module_sum_ff    <= module_sum_in;
         serial_sum_ff    <= serial_sum_in;
         wb_sum_ff        <= wb_sum_in;
         shading_sum_ff   <= shading_sum_in;
         flags_ok_ff      <= flags_ok_in;
         vendor_ok_ff     <= vendor_ok_in;
         checks_ok_ff     <= checks_ok_in;
         chan_ff          <= chan_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < WB_BYTES; i++) begin
         wb_byte_ff[i] <= wb_byte_in[i];
      end
      dsq_ff         <= dsq_in;
      metric_ff      <= metric_in;
      status_ff      <= status_in;
      rsp_payload_ff <= rsp_payload_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         awb_limit_ff       <= AWB_LIMIT_RESET;
         expected_vendor_ff <= VENDOR_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_AWB_LIMIT:       awb_limit_ff       <= csr_data;
            CSR_EXPECTED_VENDOR: expected_vendor_ff <= csr_data[7:0];
            default: begin
            end
         endcase
      end
   end

   a_error_metric_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_payload_ff.status == STATUS_GROUP_INVALID
                       || rsp_payload_ff.status == STATUS_MODULE_ERROR
                       || rsp_payload_ff.status == STATUS_CHECKSUM_ERR)
      |-> rsp_payload_ff.awb_metric == '0)
      else $error("error status carries a nonzero metric");

   a_final_starts_decide: assert property (@(posedge clock) disable iff (reset)
      req_fire && (pos == LAST_OFFSET) |=> state_ff == ST_DECIDE)
      else $error("final byte did not start the decision");

   a_busy_position_zero: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_IDLE |-> byte_position_ff == '0)
      else $error("position not rewound while computing");

   a_divide_ends_accum: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIVIDE && div_done |=> state_ff == ST_ACCUM)
      else $error("divider completion lost");

endmodule
